### sv/i2c_rts_pkg.sv
// Shared types and constants for the I2C register transaction sequencer.
package i2c_rts_pkg;

  localparam int unsigned MAX_TRANSFER = 256;

  typedef enum logic [1:0] {
    FUNC_BEGIN   = 2'd0,
    FUNC_STATUS  = 2'd1,
    FUNC_TICK    = 2'd2,
    FUNC_PAYLOAD = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START   = 4'd1,
    PH_ADDR_W  = 4'd2,
    PH_REGB    = 4'd3,
    PH_RESTART = 4'd4,
    PH_ADDR_R  = 4'd5,
    PH_RX      = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_TX      = 4'd8,
    PH_STOP    = 4'd9
  } phase_e;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_RESTART = 3'd3,
    CMD_RX_ACK  = 3'd4,
    CMD_RX_NACK = 3'd5,
    CMD_STOP    = 3'd6,
    CMD_NEED    = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    RES_OK      = 3'd0,
    RES_FAIL    = 3'd1,
    RES_NACK    = 3'd2,
    RES_ARB     = 3'd3,
    RES_TIMEOUT = 3'd4
  } res_e;

  typedef enum logic [1:0] {
    CFG_CONTROLLER_READY = 2'd0,
    CFG_TIMEOUT_LIMIT    = 2'd1
  } cfg_idx_e;

  // Core status codes.
  localparam logic [7:0] ST_BUS_ERROR  = 8'h00;
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RESTART    = 8'h10;
  localparam logic [7:0] ST_ADDR_W_ACK = 8'h18;
  localparam logic [7:0] ST_ADDR_W_NAK = 8'h20;
  localparam logic [7:0] ST_DATA_ACK   = 8'h28;
  localparam logic [7:0] ST_DATA_NAK   = 8'h30;
  localparam logic [7:0] ST_ARB_LOST   = 8'h38;
  localparam logic [7:0] ST_ADDR_R_ACK = 8'h40;
  localparam logic [7:0] ST_ADDR_R_NAK = 8'h48;
  localparam logic [7:0] ST_RX_ACK     = 8'h50;
  localparam logic [7:0] ST_RX_NACK    = 8'h58;
  localparam logic [7:0] ST_IDLE       = 8'hf8;

  // Abort class of a status code; RES_OK means the code does not abort.
  function automatic res_e abort_class(input logic [7:0] st);
    res_e cls;
    case (st)
      ST_BUS_ERROR:                              cls = RES_FAIL;
      ST_ADDR_W_NAK, ST_DATA_NAK, ST_ADDR_R_NAK: cls = RES_NACK;
      ST_ARB_LOST:                               cls = RES_ARB;
      default:                                   cls = RES_OK;
    endcase
    return cls;
  endfunction

endpackage

### sv/i2c_register_transaction_sequencer_unit.sv
// Sequencer that steps a byte-level I2C master core through register reads and writes.
//
// Input channel (in_valid_i/in_ready_o) carries one event per transfer: a begin request,
// a core status event, a time tick or a payload byte, selected by func_i. Each accepted
// event is handled in the cycle it is accepted and gives zero or one result, which
// appears on the output channel (out_valid_o/out_ready_i) in the next cycle.
// Events that give no result simply update the internal state.
// Throughput is one event per clock unless the receiver stalls: a single output register
// separates the channels, and in_ready_o stays high while that register is empty or is
// being drained in the same cycle. When the receiver stalls with a result pending,
// in_ready_o drops until the result is taken; no result is lost or repeated.
// The cfg_we_i port writes controller_ready (index 0) or timeout_limit (index 1);
// other indexes are ignored. Writes are expected only while no transfer is active.
// Reset puts the sequencer idle, clears controller_ready and sets timeout_limit to 65535.
module i2c_register_transaction_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic        is_read_i,
  input  logic [6:0]  chip_addr_i,
  input  logic [23:0] reg_addr_i,
  input  logic [1:0]  addr_len_i,
  input  logic [8:0]  byte_count_i,
  input  logic [7:0]  status_code_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  tx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  command_o,
  output logic [7:0]  tx_value_o,
  output logic        rx_valid_o,
  output logic [7:0]  rx_value_o,
  output logic        done_res_o,
  output logic [2:0]  result_code_o
);

  logic                 ctrl_ready_q;
  logic [15:0]          timeout_limit_q;
  i2c_rts_pkg::phase_e  phase_q, phase_d;
  logic                 read_mode_q, read_mode_d;
  logic [6:0]           target_addr_q, target_addr_d;
  logic [23:0]          register_addr_q, register_addr_d;
  logic [1:0]           addr_left_q, addr_left_d;
  logic [8:0]           data_left_q, data_left_d;
  i2c_rts_pkg::res_e    saved_res_q, saved_res_d;
  logic [15:0]          wait_ticks_q, wait_ticks_d;

  logic                 out_valid_q;
  i2c_rts_pkg::cmd_e    command_q, command_d;
  logic [7:0]           tx_value_q, tx_value_d;
  logic                 rx_valid_q, rx_valid_d;
  logic [7:0]           rx_value_q, rx_value_d;
  logic                 done_q, done_d;
  i2c_rts_pkg::res_e    result_q, result_d;
  logic                 emit;

  logic                 accept;
  i2c_rts_pkg::func_e   func;
  logic                 waiting;
  logic [15:0]          ticks_inc;
  logic                 tick_hit;
  logic [7:0]           expected;
  logic                 st_match;
  i2c_rts_pkg::res_e    cls;
  logic                 bad_req;
  logic [8:0]           data_dec;
  logic [1:0]           addr_dec;
  logic [7:0]           reg_byte;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign func       = i2c_rts_pkg::func_e'(func_i);

  assign waiting   = (phase_q != i2c_rts_pkg::PH_IDLE) && (phase_q != i2c_rts_pkg::PH_PAYLOAD);
  assign ticks_inc = (wait_ticks_q != 16'hffff) ? wait_ticks_q + 16'd1 : wait_ticks_q;
  // A limit of zero behaves like one, since the incremented count is always at least one.
  assign tick_hit  = ticks_inc >= timeout_limit_q;
  assign st_match  = status_code_i == expected;
  assign cls       = i2c_rts_pkg::abort_class(status_code_i);
  assign data_dec  = (data_left_q != 9'd0) ? data_left_q - 9'd1 : data_left_q;
  assign addr_dec  = addr_left_q - 2'd1;
  assign bad_req   = !ctrl_ready_q || (addr_len_i == 2'd0) ||
                     (is_read_i && (byte_count_i == 9'd0)) ||
                     (byte_count_i > 9'(i2c_rts_pkg::MAX_TRANSFER));

  always_comb begin
    case (phase_q)
      i2c_rts_pkg::PH_START:   expected = i2c_rts_pkg::ST_START;
      i2c_rts_pkg::PH_ADDR_W:  expected = i2c_rts_pkg::ST_ADDR_W_ACK;
      i2c_rts_pkg::PH_REGB:    expected = i2c_rts_pkg::ST_DATA_ACK;
      i2c_rts_pkg::PH_RESTART: expected = i2c_rts_pkg::ST_RESTART;
      i2c_rts_pkg::PH_ADDR_R:  expected = i2c_rts_pkg::ST_ADDR_R_ACK;
      i2c_rts_pkg::PH_RX: begin
        expected = (data_left_q > 9'd1) ? i2c_rts_pkg::ST_RX_ACK : i2c_rts_pkg::ST_RX_NACK;
      end
      i2c_rts_pkg::PH_TX:      expected = i2c_rts_pkg::ST_DATA_ACK;
      default:                 expected = i2c_rts_pkg::ST_IDLE;
    endcase
  end

  // Register-address bytes go out most significant first; an exhausted count sends zero.
  always_comb begin
    case (addr_dec)
      2'd0:    reg_byte = register_addr_q[7:0];
      2'd1:    reg_byte = register_addr_q[15:8];
      2'd2:    reg_byte = register_addr_q[23:16];
      default: reg_byte = 8'd0;
    endcase
  end

  // Result of the accepted event.
  always_comb begin
    emit       = 1'b0;
    command_d  = i2c_rts_pkg::CMD_NONE;
    tx_value_d = 8'd0;
    rx_valid_d = 1'b0;
    rx_value_d = 8'd0;
    done_d     = 1'b0;
    result_d   = i2c_rts_pkg::RES_OK;
    case (func)
      i2c_rts_pkg::FUNC_BEGIN: begin
        if (phase_q == i2c_rts_pkg::PH_IDLE) begin
          emit = 1'b1;
          if (bad_req) begin
            done_d   = 1'b1;
            result_d = i2c_rts_pkg::RES_FAIL;
          end else begin
            command_d = i2c_rts_pkg::CMD_START;
          end
        end
      end
      i2c_rts_pkg::FUNC_PAYLOAD: begin
        if (phase_q == i2c_rts_pkg::PH_PAYLOAD) begin
          emit       = 1'b1;
          command_d  = i2c_rts_pkg::CMD_SEND;
          tx_value_d = tx_byte_i;
        end
      end
      i2c_rts_pkg::FUNC_TICK: begin
        if (waiting && tick_hit) begin
          emit = 1'b1;
          if (phase_q == i2c_rts_pkg::PH_STOP) begin
            done_d   = 1'b1;
            result_d = saved_res_q;
          end else begin
            command_d = i2c_rts_pkg::CMD_STOP;
          end
        end
      end
      default: begin
        if (waiting && st_match) begin
          emit = 1'b1;
          case (phase_q)
            i2c_rts_pkg::PH_START: begin
              command_d  = i2c_rts_pkg::CMD_SEND;
              tx_value_d = {target_addr_q, 1'b0};
            end
            i2c_rts_pkg::PH_ADDR_W: begin
              command_d  = i2c_rts_pkg::CMD_SEND;
              tx_value_d = reg_byte;
            end
            i2c_rts_pkg::PH_REGB: begin
              if (addr_left_q != 2'd0) begin
                command_d  = i2c_rts_pkg::CMD_SEND;
                tx_value_d = reg_byte;
              end else if (read_mode_q) begin
                command_d = i2c_rts_pkg::CMD_RESTART;
              end else if (data_left_q != 9'd0) begin
                command_d = i2c_rts_pkg::CMD_NEED;
              end else begin
                command_d = i2c_rts_pkg::CMD_STOP;
              end
            end
            i2c_rts_pkg::PH_RESTART: begin
              command_d  = i2c_rts_pkg::CMD_SEND;
              tx_value_d = {target_addr_q, 1'b1};
            end
            i2c_rts_pkg::PH_ADDR_R: begin
              command_d = (data_left_q > 9'd1) ? i2c_rts_pkg::CMD_RX_ACK
                                               : i2c_rts_pkg::CMD_RX_NACK;
            end
            i2c_rts_pkg::PH_RX: begin
              rx_valid_d = 1'b1;
              rx_value_d = rx_byte_i;
              if (data_dec == 9'd0) begin
                command_d = i2c_rts_pkg::CMD_STOP;
              end else begin
                command_d = (data_dec > 9'd1) ? i2c_rts_pkg::CMD_RX_ACK
                                              : i2c_rts_pkg::CMD_RX_NACK;
              end
            end
            i2c_rts_pkg::PH_TX: begin
              command_d = (data_dec != 9'd0) ? i2c_rts_pkg::CMD_NEED : i2c_rts_pkg::CMD_STOP;
            end
            default: begin
              done_d   = 1'b1;
              result_d = saved_res_q;
            end
          endcase
        end else if (waiting && (cls != i2c_rts_pkg::RES_OK)) begin
          emit = 1'b1;
          if (phase_q == i2c_rts_pkg::PH_STOP) begin
            done_d   = 1'b1;
            result_d = saved_res_q;
          end else begin
            command_d = i2c_rts_pkg::CMD_STOP;
          end
        end
      end
    endcase
  end

  // Next state of the sequence.
  always_comb begin
    phase_d         = phase_q;
    read_mode_d     = read_mode_q;
    target_addr_d   = target_addr_q;
    register_addr_d = register_addr_q;
    addr_left_d     = addr_left_q;
    data_left_d     = data_left_q;
    saved_res_d     = saved_res_q;
    wait_ticks_d    = wait_ticks_q;
    case (func)
      i2c_rts_pkg::FUNC_BEGIN: begin
        if ((phase_q == i2c_rts_pkg::PH_IDLE) && !bad_req) begin
          read_mode_d     = is_read_i;
          target_addr_d   = chip_addr_i;
          register_addr_d = reg_addr_i;
          addr_left_d     = addr_len_i;
          data_left_d     = byte_count_i;
          saved_res_d     = i2c_rts_pkg::RES_OK;
          phase_d         = i2c_rts_pkg::PH_START;
        end
      end
      i2c_rts_pkg::FUNC_PAYLOAD: begin
        if (phase_q == i2c_rts_pkg::PH_PAYLOAD) begin
          phase_d = i2c_rts_pkg::PH_TX;
        end
      end
      i2c_rts_pkg::FUNC_TICK: begin
        if (waiting) begin
          wait_ticks_d = ticks_inc;
          if (tick_hit) begin
            if (phase_q == i2c_rts_pkg::PH_STOP) begin
              phase_d = i2c_rts_pkg::PH_IDLE;
            end else begin
              saved_res_d = i2c_rts_pkg::RES_TIMEOUT;
              phase_d     = i2c_rts_pkg::PH_STOP;
            end
          end
        end
      end
      default: begin
        if (waiting && st_match) begin
          case (phase_q)
            i2c_rts_pkg::PH_START:   phase_d = i2c_rts_pkg::PH_ADDR_W;
            i2c_rts_pkg::PH_ADDR_W: begin
              addr_left_d = addr_dec;
              phase_d     = i2c_rts_pkg::PH_REGB;
            end
            i2c_rts_pkg::PH_REGB: begin
              if (addr_left_q != 2'd0) begin
                addr_left_d = addr_dec;
              end else if (read_mode_q) begin
                phase_d = i2c_rts_pkg::PH_RESTART;
              end else if (data_left_q != 9'd0) begin
                phase_d = i2c_rts_pkg::PH_PAYLOAD;
              end else begin
                saved_res_d = i2c_rts_pkg::RES_OK;
                phase_d     = i2c_rts_pkg::PH_STOP;
              end
            end
            i2c_rts_pkg::PH_RESTART: phase_d = i2c_rts_pkg::PH_ADDR_R;
            i2c_rts_pkg::PH_ADDR_R:  phase_d = i2c_rts_pkg::PH_RX;
            i2c_rts_pkg::PH_RX: begin
              data_left_d = data_dec;
              if (data_dec == 9'd0) begin
                saved_res_d = i2c_rts_pkg::RES_OK;
                phase_d     = i2c_rts_pkg::PH_STOP;
              end
            end
            i2c_rts_pkg::PH_TX: begin
              data_left_d = data_dec;
              if (data_dec != 9'd0) begin
                phase_d = i2c_rts_pkg::PH_PAYLOAD;
              end else begin
                saved_res_d = i2c_rts_pkg::RES_OK;
                phase_d     = i2c_rts_pkg::PH_STOP;
              end
            end
            default: phase_d = i2c_rts_pkg::PH_IDLE;
          endcase
        end else if (waiting && (cls != i2c_rts_pkg::RES_OK)) begin
          if (phase_q == i2c_rts_pkg::PH_STOP) begin
            phase_d = i2c_rts_pkg::PH_IDLE;
          end else begin
            saved_res_d = cls;
            phase_d     = i2c_rts_pkg::PH_STOP;
          end
        end
      end
    endcase
    // Every issued result restarts the status wait.
    if (emit) begin
      wait_ticks_d = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_ready_q    <= 1'b0;
      timeout_limit_q <= 16'hffff;
    end else if (cfg_we_i) begin
      case (i2c_rts_pkg::cfg_idx_e'(cfg_index_i))
        i2c_rts_pkg::CFG_CONTROLLER_READY: ctrl_ready_q    <= cfg_data_i[0];
        i2c_rts_pkg::CFG_TIMEOUT_LIMIT:    timeout_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= i2c_rts_pkg::PH_IDLE;
      read_mode_q     <= 1'b0;
      target_addr_q   <= 7'd0;
      register_addr_q <= 24'd0;
      addr_left_q     <= 2'd0;
      data_left_q     <= 9'd0;
      saved_res_q     <= i2c_rts_pkg::RES_OK;
      wait_ticks_q    <= 16'd0;
    end else if (accept) begin
      phase_q         <= phase_d;
      read_mode_q     <= read_mode_d;
      target_addr_q   <= target_addr_d;
      register_addr_q <= register_addr_d;
      addr_left_q     <= addr_left_d;
      data_left_q     <= data_left_d;
      saved_res_q     <= saved_res_d;
      wait_ticks_q    <= wait_ticks_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      command_q  <= command_d;
      tx_value_q <= tx_value_d;
      rx_valid_q <= rx_valid_d;
      rx_value_q <= rx_value_d;
      done_q     <= done_d;
      result_q   <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign command_o     = command_q;
  assign tx_value_o    = tx_value_q;
  assign rx_valid_o    = rx_valid_q;
  assign rx_value_o    = rx_value_q;
  assign done_res_o    = done_q;
  assign result_code_o = result_q;

endmodule
